// ----- hw/rtl/jlma_pkg.sv -----
// Package for the jump-limited moving average: transaction payload types and
// fixed field widths. Depends on nothing; imported by jump_limited_moving_average.
package jlma_pkg;

   localparam int XY_W           = 32;
   localparam int JUMP_W         = 31;
   localparam int IDX_W          = 11;
   localparam int IDX_MAX        = 2047;
   localparam logic [JUMP_W-1:0] MAX_JUMP_RESET = 31'd327680;

   // Half the window length. The window of 2H points must be a power of two,
   // because the mean is taken with a shift.
   localparam int HALF_WINDOW    = 8;

   typedef struct packed {
      logic                   start_req;
      logic signed [XY_W-1:0] x_sample;
      logic signed [XY_W-1:0] y_sample;
   } req_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x_out;
      logic signed [XY_W-1:0] y_out;
      logic                   was_averaged;
      logic [IDX_W-1:0]       point_index;
   } rsp_type;

endpackage

// ----- hw/rtl/jump_limited_moving_average.sv -----
// Jump-limited boxcar moving average over profile points; uses jlma_pkg.
// A point that completes a window gives its result in the cycle after acceptance,
// from the single result register behind the combinational window logic.
// Throughput: one point per cycle; only a result waiting at the output holds off input.
// Reset (synchronous): clears fill count, sums, index and the result flag; limit = 5.0 mm.
module jump_limited_moving_average #(
   parameter int MAX_POINTS  = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  jlma_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output jlma_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [jlma_pkg::JUMP_W-1:0]        csr_wdata
);
   import jlma_pkg::*;

   // The window length 2H is a power of two, so dividing the window sum by it
   // is a plain shift of the sum.
   localparam int WIN       = 2 * HALF_WINDOW;
   localparam int WIN_LOG   = $clog2(WIN);
   localparam int FILL_W    = $clog2(WIN + 1);
   localparam int SUM_W     = XY_W + WIN_LOG;
   localparam int IW        = IDX_W + 1;
   localparam int IDX_LIM   = (MAX_POINTS - 1 < IDX_MAX) ? MAX_POINTS - 1 : IDX_MAX;

   // Configuration: the jump limit register. Writes are always taken.
   logic [JUMP_W-1:0] max_jump_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_jump_ff <= MAX_JUMP_RESET;
      end else if (csr_valid) begin
         max_jump_ff <= csr_wdata;
      end
   end

   // Stream state. The delay line holds the last 2H points, newest at entry 0.
   // Entry H-1 is the centre point and entry 2H-1 is the oldest window member.
   logic signed [XY_W-1:0]  x_delay_ff [WIN];
   logic signed [XY_W-1:0]  y_delay_ff [WIN];
   logic signed [SUM_W-1:0] x_sum_ff;
   logic signed [SUM_W-1:0] y_sum_ff;
   logic signed [SUM_W-1:0] x_sum_in;
   logic signed [SUM_W-1:0] y_sum_in;
   logic [FILL_W-1:0]       fill_ff;
   logic [FILL_W-1:0]       fill_in;
   logic [IDX_W-1:0]        centre_ff;
   logic [IDX_W-1:0]        centre_in;

   logic                    accept;
   logic                    emit;
   logic [FILL_W-1:0]       eff_fill;
   logic signed [SUM_W-1:0] eff_x_sum;
   logic signed [SUM_W-1:0] eff_y_sum;
   logic [IDX_W-1:0]        eff_centre;
   logic signed [XY_W:0]    dx;
   logic signed [XY_W:0]    dy;
   logic [XY_W:0]           adx;
   logic [XY_W:0]           ady;
   logic                    avg;
   logic [IW-1:0]           idx_sum;
   logic [IDX_W-1:0]        point_idx;
   logic signed [SUM_W-1:0] x_round;
   logic signed [SUM_W-1:0] y_round;

   // Result register.
   logic                    rsp_load_ok;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_valid_ff;

   // The result register can load when it is empty or its transaction leaves
   // in this cycle. Input waits only while a finished result is held.
   assign rsp_load_ok = !rsp_valid_ff || rsp_ready;
   assign req_ready   = rsp_load_ok;
   assign accept      = req_valid && req_ready;

   // A start point sees an empty profile: fill, sums and index count as zero.
   always_comb begin
      eff_fill   = req_data.start_req ? '0 : fill_ff;
      eff_x_sum  = req_data.start_req ? '0 : x_sum_ff;
      eff_y_sum  = req_data.start_req ? '0 : y_sum_ff;
      eff_centre = req_data.start_req ? '0 : centre_ff;
      emit       = (eff_fill >= FILL_W'(WIN));

      // Jump test between the window's oldest point and the new point, on
      // exact 33-bit differences.
      dx  = (XY_W + 1)'(x_delay_ff[WIN-1]) - (XY_W + 1)'(req_data.x_sample);
      dy  = (XY_W + 1)'(y_delay_ff[WIN-1]) - (XY_W + 1)'(req_data.y_sample);
      adx = dx[XY_W] ? (XY_W + 1)'(-dx) : (XY_W + 1)'(dx);
      ady = dy[XY_W] ? (XY_W + 1)'(-dy) : (XY_W + 1)'(dy);
      avg = (adx < (XY_W + 1)'(max_jump_ff)) && (ady < (XY_W + 1)'(max_jump_ff));

      idx_sum   = IW'(HALF_WINDOW) + IW'(eff_centre);
      point_idx = (idx_sum > IW'(IDX_LIM)) ? IDX_W'(IDX_LIM) : idx_sum[IDX_W-1:0];

      // Running sums drop the oldest point once the window is full.
      x_sum_in = eff_x_sum + SUM_W'(req_data.x_sample);
      y_sum_in = eff_y_sum + SUM_W'(req_data.y_sample);
      if (emit) begin
         x_sum_in = x_sum_in - SUM_W'(x_delay_ff[WIN-1]);
         y_sum_in = y_sum_in - SUM_W'(y_delay_ff[WIN-1]);
      end

      fill_in   = (eff_fill < FILL_W'(WIN)) ? eff_fill + FILL_W'(1) : eff_fill;
      centre_in = eff_centre;
      if (emit && (eff_centre < IDX_W'(IDX_LIM))) begin
         centre_in = eff_centre + IDX_W'(1);
      end

      // The mean is floor((sum + H) / 2H): adding H and dropping the low
      // WIN_LOG bits rounds to nearest with ties toward plus infinity. The
      // mean of 32-bit points always fits in 32 bits.
      x_round = eff_x_sum + SUM_W'(HALF_WINDOW);
      y_round = eff_y_sum + SUM_W'(HALF_WINDOW);

      // Choice between the mean and the raw centre point.
      rsp_in.x_out        = avg ? x_round[WIN_LOG +: XY_W] : x_delay_ff[HALF_WINDOW-1];
      rsp_in.y_out        = avg ? y_round[WIN_LOG +: XY_W] : y_delay_ff[HALF_WINDOW-1];
      rsp_in.was_averaged = avg;
      rsp_in.point_index  = point_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_sum_ff  <= '0;
         y_sum_ff  <= '0;
         fill_ff   <= '0;
         centre_ff <= '0;
      end else if (accept) begin
         x_sum_ff  <= x_sum_in;
         y_sum_ff  <= y_sum_in;
         fill_ff   <= fill_in;
         centre_ff <= centre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_delay_ff[0] <= req_data.x_sample;
         y_delay_ff[0] <= req_data.y_sample;
         for (int k = 1; k < WIN; k++) begin
            x_delay_ff[k] <= x_delay_ff[k-1];
            y_delay_ff[k] <= y_delay_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load_ok) begin
         rsp_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // A start transaction leaves exactly one point in the new profile.
   a_start_fill: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.start_req |=> fill_ff == FILL_W'(1))
      else $error("fill count wrong after start transaction");

   // Only a transaction that completes a window produces a result.
   a_no_emit_empty: assert property (@(posedge clock) disable iff (reset)
      accept && !emit |=> !rsp_valid_ff)
      else $error("non-emitting transaction produced a result");

   // A zero jump limit never selects the mean.
   a_zero_limit_raw: assert property (@(posedge clock) disable iff (reset)
      accept && emit && (max_jump_ff == '0) |=> !rsp_ff.was_averaged)
      else $error("mean selected with zero jump limit");

   // A result that is not taken stays in place unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("waiting result changed or dropped");
`endif

endmodule

// ----- test/jlma_predict_check.sv -----
// Predicts and checks the results of jump_limited_moving_average from its channels.
// Depends on jlma_pkg for the payload types and field widths; it is instantiated
// beside the block by jump_limited_moving_average_tb.
module jlma_predict_check #(
   parameter int MAX_POINTS  = 2048
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  jlma_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  jlma_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [jlma_pkg::JUMP_W-1:0] csr_wdata,
   output int                          mismatch_count,
   output int                          outstanding
);
   import jlma_pkg::*;

   localparam int WIN         = 2 * HALF_WINDOW;
   localparam int DEPTH       = WIN + 1;
   localparam int SUM_W       = XY_W + $clog2(WIN) + 1;
   localparam int INDEX_CAP   = (MAX_POINTS - 1 < IDX_MAX) ? MAX_POINTS - 1 : IDX_MAX;
   localparam int REPORT_MAX  = 10;
   localparam int QUEUE_DEPTH = 64;

   logic [JUMP_W-1:0]      jump_limit;
   logic signed [XY_W-1:0] x_line [DEPTH];
   logic signed [XY_W-1:0] y_line [DEPTH];
   logic signed [SUM_W-1:0] x_sum;
   logic signed [SUM_W-1:0] y_sum;
   int                     points_held;
   int                     centres_done;
   int                     failures = 0;
   // Predicted results in order, kept in a ring.
   rsp_type                expected_points [QUEUE_DEPTH];
   int                     exp_head;
   int                     exp_tail;
   int                     exp_count;

   // Mean of the window, rounded to nearest with ties toward plus infinity.
   function automatic logic signed [XY_W-1:0] window_mean(input logic signed [SUM_W-1:0] s);
      longint biased;
      longint q;
      biased = longint'(s) + HALF_WINDOW;
      q = biased / WIN;
      if ((biased % WIN) != 0 && biased < 0) q -= 1;
      return q[XY_W-1:0];
   endfunction

   function automatic void store_expected(input rsp_type r);
      if (exp_count < QUEUE_DEPTH) begin
         expected_points[exp_tail] = r;
         exp_tail = (exp_tail + 1) % QUEUE_DEPTH;
         exp_count++;
      end else begin
         failures++;
         if (failures <= REPORT_MAX)
            $display("too many results pending in the checker");
      end
   endfunction

   function automatic void take_point(input req_type p);
      logic signed [XY_W-1:0] nx;
      logic signed [XY_W-1:0] ny;
      longint                 dx;
      longint                 dy;
      int                     idx;
      bit                     averaged;
      rsp_type                r;
      nx = p.x_sample;
      ny = p.y_sample;
      if (p.start_req) begin
         points_held = 0;
         centres_done = 0;
         x_sum = '0;
         y_sum = '0;
      end
      if (points_held >= WIN) begin
         // The line holds centre+H-1 down to centre-H; the new point is centre+H.
         dx = longint'(x_line[WIN-1]) - longint'(nx);
         dy = longint'(y_line[WIN-1]) - longint'(ny);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         averaged = (dx < longint'(jump_limit)) && (dy < longint'(jump_limit));
         idx = HALF_WINDOW + centres_done;
         if (idx > INDEX_CAP) idx = INDEX_CAP;
         r.x_out = averaged ? window_mean(x_sum) : x_line[HALF_WINDOW-1];
         r.y_out = averaged ? window_mean(y_sum) : y_line[HALF_WINDOW-1];
         r.was_averaged = averaged;
         r.point_index = idx[IDX_W-1:0];
         store_expected(r);
         if (centres_done < INDEX_CAP) centres_done++;
         x_sum = x_sum - x_line[WIN-1];
         y_sum = y_sum - y_line[WIN-1];
      end
      x_sum = x_sum + nx;
      y_sum = y_sum + ny;
      for (int k = DEPTH - 1; k > 0; k--) begin
         x_line[k] = x_line[k-1];
         y_line[k] = y_line[k-1];
      end
      x_line[0] = nx;
      y_line[0] = ny;
      if (points_held < DEPTH) points_held++;
   endfunction

   function automatic void compare_result(input rsp_type got);
      rsp_type want;
      if (exp_count == 0) begin
         failures++;
         if (failures <= REPORT_MAX)
            $display("unexpected result: x=%0d y=%0d averaged=%0b index=%0d",
                     got.x_out, got.y_out, got.was_averaged, got.point_index);
      end else begin
         want = expected_points[exp_head];
         exp_head = (exp_head + 1) % QUEUE_DEPTH;
         exp_count--;
         if (got.x_out !== want.x_out || got.y_out !== want.y_out ||
             got.was_averaged !== want.was_averaged ||
             got.point_index !== want.point_index) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("result mismatch: expected x=%0d y=%0d averaged=%0b index=%0d, %s",
                        want.x_out, want.y_out, want.was_averaged, want.point_index,
                        $sformatf("got x=%0d y=%0d averaged=%0b index=%0d",
                                  got.x_out, got.y_out, got.was_averaged,
                                  got.point_index));
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         jump_limit = MAX_JUMP_RESET;
         x_sum = '0;
         y_sum = '0;
         points_held = 0;
         centres_done = 0;
         exp_head = 0;
         exp_tail = 0;
         exp_count = 0;
      end else begin
         if (csr_valid && csr_ready) jump_limit = csr_wdata;
         if (req_valid && req_ready) take_point(req_data);
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
      end
      mismatch_count <= failures;
      outstanding <= exp_count;
   end

endmodule

// ----- test/jump_limited_moving_average_tb.sv -----
// Top of the testbench for jump_limited_moving_average: clock, reset, stimulus and verdict.
// Depends on jlma_pkg and on jlma_predict_check, which predicts and compares the results.
module jump_limited_moving_average_tb;
   import jlma_pkg::*;

   localparam int MAX_POINTS  = 2048;
   // The block answers in the cycle after it accepts the point that completes a
   // window; the tail wait after draining is well beyond that.
   localparam int SETTLE_CYCLES  = 20;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_POINTS  = 640;
   localparam int LONG_PROFILE   = 100;
   localparam logic signed [XY_W-1:0] XY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [XY_W-1:0] XY_MIN = 32'sh8000_0000;
   localparam logic [JUMP_W-1:0] JUMP_TOP = 31'h7FFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [JUMP_W-1:0] csr_wdata = MAX_JUMP_RESET;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   // Chance in percent that the sender idles in a given cycle, and that the
   // receiver stalls in a given cycle.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   always #6 clock = ~clock;

   jump_limited_moving_average #(
      .MAX_POINTS (MAX_POINTS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   jlma_predict_check #(
      .MAX_POINTS (MAX_POINTS)
   ) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   // The receiver decides afresh at every edge whether it takes a result.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offers one point and returns at the edge where the transaction is accepted.
   // Valid stays high on return, so back-to-back points never drop it; idle
   // cycles before the point lower it.
   task automatic send_point(input logic start, input logic signed [XY_W-1:0] x,
                             input logic signed [XY_W-1:0] y);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{start_req: start, x_sample: x, y_sample: y};
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every predicted result has arrived, then lets
   // the block finish any point that has no result of its own. The checker
   // publishes its count from a register, hence the first edge.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The jump limit is only rewritten once the block has gone quiet.
   task automatic write_limit(input logic [JUMP_W-1:0] value);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly a random walk of about two millimetres a step, so that the jump test
   // goes both ways under the default limit, with larger jumps, full-range noise
   // and the extreme values mixed in.
   function automatic logic signed [XY_W-1:0] next_coord(input logic signed [XY_W-1:0] prev);
      int          pick;
      int          step;
      logic [31:0] offset;
      pick = $urandom_range(99);
      if (pick < 70) begin
         step = int'($urandom_range(262144)) - 131072;
         return prev + step;
      end else if (pick < 82) begin
         offset = $urandom() & 32'h00FF_FFFF;
         return $urandom_range(1) ? prev + offset : prev - offset;
      end else if (pick < 95) begin
         return $urandom();
      end else begin
         case ($urandom_range(3))
            0: return XY_MAX;
            1: return XY_MIN;
            2: return '0;
            default: return -1;
         endcase
      end
   endfunction

   // One profile: a start point followed by length-1 points of the same scan.
   task automatic send_profile(input int length);
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      x = $urandom();
      y = $urandom();
      for (int k = 0; k < length; k++) begin
         x = next_coord(x);
         y = next_coord(y);
         send_point(k == 0, x, y);
      end
   endtask

   // Most profiles are long enough to produce results; the rest end before any
   // result and are cut short by the next start.
   task automatic run_profiles(input int budget);
      int sent;
      int length;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 80)
            length = $urandom_range(60, 2 * HALF_WINDOW + 1);
         else
            length = $urandom_range(2 * HALF_WINDOW, 1);
         if (length > budget - sent) length = budget - sent;
         send_profile(length);
         sent += length;
      end
   endtask

   initial begin
      int                idle_by_phase  [4];
      int                stall_by_phase [4];
      logic [JUMP_W-1:0] limit_by_phase [4];

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed profile under the reset limit of 5 mm. The first window holds
      // x at its maximum and y summing to minus a half step, so the first
      // centre averages to the top of the range in x and rounds a tie up to
      // zero in y.
      send_point(1'b1, XY_MAX, -8);
      for (int k = 1; k < 2 * HALF_WINDOW + 1; k++) send_point(1'b0, XY_MAX, 0);
      // An x jump over the full 33-bit span forces the raw centre.
      send_point(1'b0, XY_MIN, 0);
      // A y difference exactly at the limit is not below it, so this one is raw.
      send_point(1'b0, XY_MAX, 32'sd327680);
      // A start in the middle of a profile drops the fill and the index; the
      // points after it only refill the window.
      send_point(1'b1, XY_MIN, XY_MAX);
      send_point(1'b0, -1, XY_MIN);
      send_point(1'b0, 0, -1);
      send_point(1'b0, XY_MAX, 0);
      send_point(1'b0, 1, 32'sh0001_0000);

      // Random phases, each with its own pacing and jump limit. Every limit
      // write drains the block first, so the sender pauses until all results
      // are in between phases.
      idle_by_phase  = '{0, 68, 0, 16};
      stall_by_phase = '{0, 0, 68, 16};
      limit_by_phase = '{JUMP_TOP, '0, JUMP_W'($urandom_range(1 << 22, 1)), MAX_JUMP_RESET};
      for (int phase = 0; phase < 4; phase++) begin
         write_limit(limit_by_phase[phase]);
         sender_idle_pct = idle_by_phase[phase];
         receiver_stall_pct <= stall_by_phase[phase];
         run_profiles(RANDOM_POINTS / 4);
      end

      // One longer profile sent at full rate under a random limit.
      write_limit(JUMP_W'($urandom()));
      sender_idle_pct = 0;
      receiver_stall_pct <= 0;
      send_profile(LONG_PROFILE);

      wait_for_drain();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/jlma_pkg.sv
hw/rtl/jump_limited_moving_average.sv
test/jlma_predict_check.sv
test/jump_limited_moving_average_tb.sv
